FILE: hw/rtl/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg: shared types, constants and helpers of the decimal token parser
// Item structs, phase codes, register indexes and code unit classification.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int UNIT_W      = 16;
  localparam int TEXT_W      = 64;
  localparam int LEN_W       = 3;
  localparam int MAG_W       = 32;
  localparam int PROD_W      = MAG_W + 4;
  // At most four digits are replayed when the sign resolves, so 9999 fits.
  localparam int SHORT_W     = 14;
  localparam int PHASE_W     = 3;
  localparam int ALIVE_W     = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int MINUS_COUNT = 7;

  // Token phases
  localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TWS    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_NUL    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_POSITIVE_TEXT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POSITIVE_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEGATIVE_TEXT   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NEGATIVE_LENGTH = 2'd3;

  localparam logic [LEN_W-1:0] PREFIX_UNITS = 3'd4;

  localparam logic [TEXT_W-1:0] POSITIVE_TEXT_RST   = 64'd43;
  localparam logic [LEN_W-1:0]  POSITIVE_LENGTH_RST = 3'd1;
  localparam logic [TEXT_W-1:0] NEGATIVE_TEXT_RST   = 64'd45;
  localparam logic [LEN_W-1:0]  NEGATIVE_LENGTH_RST = 3'd1;

  localparam logic [UNIT_W-1:0] CU_NUL    = 16'h0000;
  localparam logic [UNIT_W-1:0] CU_SPACE  = 16'h0020;
  localparam logic [UNIT_W-1:0] CU_HYPHEN = 16'h002D;

  localparam logic [UNIT_W-1:0] MINUS_LIKE [MINUS_COUNT] = '{
    16'h2012, 16'h207B, 16'h208B, 16'h2212, 16'h2796, 16'hFE63, 16'hFF0D
  };

  localparam logic [MAG_W-1:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [MAG_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              last_unit;
  } in_item_t;

  typedef struct packed {
    logic                    ok;
    logic signed [MAG_W-1:0] number_value;
  } out_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               digit_seen;
    logic               failed;
  } body_ctl_t;

  function automatic logic is_ws(input logic [UNIT_W-1:0] c);
    return (c == CU_SPACE) || (c inside {[16'd9:16'd13]});
  endfunction

  function automatic logic is_digit(input logic [UNIT_W-1:0] c);
    return c inside {[16'h0030:16'h0039]};
  endfunction

  function automatic logic is_minus_like(input logic [UNIT_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < MINUS_COUNT; i++) begin
      if (c == MINUS_LIKE[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    return (len > PREFIX_UNITS) ? PREFIX_UNITS : len;
  endfunction

  function automatic logic [UNIT_W-1:0] unit_of(input logic [TEXT_W-1:0] text,
                                                input logic [1:0]        idx);
    return text[UNIT_W*idx +: UNIT_W];
  endfunction

  // Phase and flag update of the body once the sign is settled.
  function automatic body_ctl_t next_ctl(input body_ctl_t         ctl,
                                         input logic [UNIT_W-1:0] c,
                                         input logic              ovf);
    body_ctl_t n;
    n = ctl;
    if (!ctl.failed) begin
      case (ctl.phase)
        PH_DIGITS: begin
          if (is_digit(c)) begin
            n.digit_seen = 1'b1;
            if (ovf) n.failed = 1'b1;
          end else if (!ctl.digit_seen) begin
            n.failed = 1'b1;
          end else if (is_ws(c)) begin
            n.phase = PH_TWS;
          end else if (c == CU_NUL) begin
            n.phase = PH_NUL;
          end else begin
            n.failed = 1'b1;
          end
        end
        PH_TWS: begin
          if (c == CU_NUL) n.phase = PH_NUL;
          else if (!is_ws(c)) n.failed = 1'b1;
        end
        default: begin
          if (c != CU_NUL) n.failed = 1'b1;
        end
      endcase
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/decimal_int32_token_parser_unit.sv
// ----------------------------------------------------------------------------
// decimal_int32_token_parser_unit: UTF-16 decimal token to int32
// rst clears token state. A result goes to the output register, or the skid entry
// while that is held. One code unit per cycle while in_ready is high; the sign
// decision and the held prefix replay finish in the cycle of the deciding unit.
// ----------------------------------------------------------------------------
module decimal_int32_token_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dtp_pkg::in_item_t                   in_item,
  // result item channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output dtp_pkg::out_item_t                  out_item,
  // configuration write port
  input  logic                                cfg_write,
  input  logic [dtp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [dtp_pkg::TEXT_W-1:0]          cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers: sign prefixes, first unit in the low bits.
  // --------------------------------------------------------------------------
  logic [dtp_pkg::TEXT_W-1:0] positive_text;
  logic [dtp_pkg::LEN_W-1:0]  positive_length;
  logic [dtp_pkg::TEXT_W-1:0] negative_text;
  logic [dtp_pkg::LEN_W-1:0]  negative_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      positive_text   <= dtp_pkg::POSITIVE_TEXT_RST;
      positive_length <= dtp_pkg::POSITIVE_LENGTH_RST;
      negative_text   <= dtp_pkg::NEGATIVE_TEXT_RST;
      negative_length <= dtp_pkg::NEGATIVE_LENGTH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dtp_pkg::CFG_POSITIVE_TEXT:   positive_text   <= cfg_data;
        dtp_pkg::CFG_POSITIVE_LENGTH: positive_length <= cfg_data[dtp_pkg::LEN_W-1:0];
        dtp_pkg::CFG_NEGATIVE_TEXT:   negative_text   <= cfg_data;
        dtp_pkg::CFG_NEGATIVE_LENGTH: negative_length <= cfg_data[dtp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Token state
  // --------------------------------------------------------------------------
  logic [dtp_pkg::PHASE_W-1:0] phase;
  logic [dtp_pkg::LEN_W-1:0]   positive_match_count;
  logic [dtp_pkg::LEN_W-1:0]   negative_match_count;
  // bit 0: positive prefix, bit 1: negative prefix, bit 2: plain hyphen
  logic [dtp_pkg::ALIVE_W-1:0] sign_candidates_alive;
  logic                        is_negative;
  logic [dtp_pkg::MAG_W-1:0]   magnitude;
  logic                        digit_seen;
  logic                        failed;

  logic [dtp_pkg::PHASE_W-1:0] phase_next;
  logic [dtp_pkg::LEN_W-1:0]   positive_match_count_next;
  logic [dtp_pkg::LEN_W-1:0]   negative_match_count_next;
  logic [dtp_pkg::ALIVE_W-1:0] sign_candidates_alive_next;
  logic                        is_negative_next;
  logic [dtp_pkg::MAG_W-1:0]   magnitude_next;
  logic                        digit_seen_next;
  logic                        failed_next;

  logic                         in_accept;
  logic [dtp_pkg::UNIT_W-1:0]   c;
  logic                         last;
  logic [dtp_pkg::LEN_W-1:0]    plen;
  logic [dtp_pkg::LEN_W-1:0]    nlen;

  // sign matching
  logic                         sign_active;
  logic [dtp_pkg::ALIVE_W-1:0]  alive_start;
  logic [dtp_pkg::LEN_W-1:0]    pc_start;
  logic [dtp_pkg::LEN_W-1:0]    nc_start;
  logic [dtp_pkg::ALIVE_W-1:0]  alive_upd;
  logic [dtp_pkg::LEN_W-1:0]    pc_upd;
  logic [dtp_pkg::LEN_W-1:0]    nc_upd;
  logic [dtp_pkg::LEN_W-1:0]    held_units;
  logic [dtp_pkg::LEN_W-1:0]    taken_units;
  logic                         src_pos;
  logic                         src_neg;
  logic [dtp_pkg::TEXT_W-1:0]   src_text;
  logic                         sign_wait;
  logic [dtp_pkg::LEN_W-1:0]    win_len;
  logic                         win_neg;

  // replay of held units plus the deciding unit, from an empty body
  logic [dtp_pkg::UNIT_W-1:0]   rp_unit [4];
  logic                         rp_en   [4];
  dtp_pkg::body_ctl_t           sh_ctl;
  logic [dtp_pkg::SHORT_W-1:0]  sh_mag;
  logic [dtp_pkg::SHORT_W-1:0]  sh_prod;

  // body path once the sign is settled
  dtp_pkg::body_ctl_t           body_ctl;
  dtp_pkg::body_ctl_t           body_ctl_next;
  logic [dtp_pkg::PROD_W-1:0]   body_prod;
  logic [dtp_pkg::PROD_W-1:0]   body_limit;
  logic                         body_ovf;

  dtp_pkg::out_item_t           result;
  logic                         result_ok;

  assign in_accept = in_valid && in_ready;
  assign c         = in_item.code_unit;
  assign last      = in_item.last_unit;
  assign plen      = dtp_pkg::eff_len(positive_length);
  assign nlen      = dtp_pkg::eff_len(negative_length);
  assign body_ctl  = '{phase: phase, digit_seen: digit_seen, failed: failed};

  // Sign prefix matching. On entry from leading whitespace the candidates are
  // set up from the registers; the hyphen candidate exists only when the
  // negative prefix is a single minus-like unit.
  always_comb begin
    sign_active = ((phase == dtp_pkg::PH_LEAD) && !dtp_pkg::is_ws(c)) ||
                  (phase == dtp_pkg::PH_SIGN);
    if (phase == dtp_pkg::PH_LEAD) begin
      alive_start = {(nlen == 3'd1) &&
                       dtp_pkg::is_minus_like(dtp_pkg::unit_of(negative_text, 2'd0)),
                     nlen != '0, plen != '0};
      pc_start    = '0;
      nc_start    = '0;
    end else begin
      alive_start = sign_candidates_alive;
      pc_start    = positive_match_count;
      nc_start    = negative_match_count;
    end

    // units already held in the sign phase
    held_units = alive_start[0] ? pc_start : (alive_start[1] ? nc_start : '0);
    src_pos    = alive_start[0];
    src_neg    = !alive_start[0] && alive_start[1] && (nc_start < nlen);
    src_text   = src_pos ? positive_text : (src_neg ? negative_text : '0);

    alive_upd = alive_start;
    pc_upd    = pc_start;
    nc_upd    = nc_start;
    if (alive_upd[0]) begin
      if ((pc_start < plen) && (c == dtp_pkg::unit_of(positive_text, pc_start[1:0])))
        pc_upd = pc_start + 3'd1;
      else
        alive_upd[0] = 1'b0;
    end
    if (alive_upd[1] && (nc_start < nlen)) begin
      if (c == dtp_pkg::unit_of(negative_text, nc_start[1:0]))
        nc_upd = nc_start + 3'd1;
      else
        alive_upd[1] = 1'b0;
    end
    // hyphen only counts as the very first sign unit
    if (alive_upd[2] && (held_units == '0) && (c != dtp_pkg::CU_HYPHEN))
      alive_upd[2] = 1'b0;
    taken_units = held_units + 3'd1;
    // a prefix cut short by the end of the token does not match
    if (last) begin
      if (alive_upd[0] && (pc_upd < plen)) alive_upd[0] = 1'b0;
      if (alive_upd[1] && (nc_upd < nlen)) alive_upd[1] = 1'b0;
    end

    // hold while a longer winning prefix may still match
    sign_wait = (alive_upd[0] && (pc_upd < plen)) ||
                (!alive_upd[0] && alive_upd[1] && (nc_upd < nlen));
    if (alive_upd[0]) begin
      win_len = plen;
      win_neg = 1'b0;
    end else if (alive_upd[1]) begin
      win_len = nlen;
      win_neg = 1'b1;
    end else if (alive_upd[2]) begin
      win_len = 3'd1;
      win_neg = 1'b1;
    end else begin
      win_len = '0;
      win_neg = 1'b0;
    end

    // Units held beyond the winning prefix go back through the body logic,
    // followed by the deciding unit.
    for (int i = 0; i < 3; i++) begin
      rp_unit[i] = dtp_pkg::unit_of(src_text, 2'(i));
      rp_en[i]   = (src_pos || src_neg) && (3'(i) >= win_len) && (3'(i + 1) < taken_units);
    end
    rp_unit[3] = c;
    rp_en[3]   = win_len < taken_units;

    sh_ctl  = '{phase: dtp_pkg::PH_DIGITS, digit_seen: 1'b0, failed: 1'b0};
    sh_mag  = '0;
    sh_prod = '0;
    for (int j = 0; j < 4; j++) begin
      if (rp_en[j]) begin
        sh_prod = (sh_mag << 3) + (sh_mag << 1) + dtp_pkg::SHORT_W'(rp_unit[j][3:0]);
        if (!sh_ctl.failed && (sh_ctl.phase == dtp_pkg::PH_DIGITS) &&
            dtp_pkg::is_digit(rp_unit[j]))
          sh_mag = sh_prod;
        sh_ctl = dtp_pkg::next_ctl(sh_ctl, rp_unit[j], 1'b0);
      end
    end
  end

  // Body path: multiply by ten, add the digit, check the int32 range.
  always_comb begin
    body_prod  = ({4'b0000, magnitude} << 3) + ({4'b0000, magnitude} << 1) +
                 dtp_pkg::PROD_W'(c[3:0]);
    body_limit = {4'b0000, is_negative ? dtp_pkg::NEG_LIMIT : dtp_pkg::POS_LIMIT};
    body_ovf   = body_prod > body_limit;
    body_ctl_next = dtp_pkg::next_ctl(body_ctl, c, body_ovf);
  end

  // Next token state and the result for a last unit
  always_comb begin
    phase_next                 = phase;
    positive_match_count_next  = positive_match_count;
    negative_match_count_next  = negative_match_count;
    sign_candidates_alive_next = sign_candidates_alive;
    is_negative_next           = is_negative;
    magnitude_next             = magnitude;
    digit_seen_next            = digit_seen;
    failed_next                = failed;

    if (sign_active) begin
      positive_match_count_next  = pc_upd;
      negative_match_count_next  = nc_upd;
      sign_candidates_alive_next = alive_upd;
      if (sign_wait) begin
        phase_next = dtp_pkg::PH_SIGN;
      end else begin
        phase_next       = sh_ctl.phase;
        digit_seen_next  = sh_ctl.digit_seen;
        failed_next      = sh_ctl.failed;
        is_negative_next = win_neg;
        magnitude_next   = {{(dtp_pkg::MAG_W - dtp_pkg::SHORT_W){1'b0}}, sh_mag};
      end
    end else if (phase != dtp_pkg::PH_LEAD) begin
      phase_next      = body_ctl_next.phase;
      digit_seen_next = body_ctl_next.digit_seen;
      failed_next     = body_ctl_next.failed;
      if (!failed && (phase == dtp_pkg::PH_DIGITS) && dtp_pkg::is_digit(c) && !body_ovf)
        magnitude_next = body_prod[dtp_pkg::MAG_W-1:0];
    end

    result_ok = !failed_next && digit_seen_next && (phase_next >= dtp_pkg::PH_DIGITS);
    result.ok = result_ok;
    if (!result_ok)
      result.number_value = '0;
    else if (is_negative_next)
      result.number_value = $signed(dtp_pkg::MAG_W'(0) - magnitude_next);
    else
      result.number_value = $signed(magnitude_next);
  end

  // Advance the token on each accepted unit; drop back to leading whitespace
  // after the last one.
  always_ff @(posedge clk) begin
    if (rst || (in_accept && last)) begin
      phase                 <= dtp_pkg::PH_LEAD;
      positive_match_count  <= '0;
      negative_match_count  <= '0;
      sign_candidates_alive <= '1;
      is_negative           <= 1'b0;
      magnitude             <= '0;
      digit_seen            <= 1'b0;
      failed                <= 1'b0;
    end else if (in_accept) begin
      phase                 <= phase_next;
      positive_match_count  <= positive_match_count_next;
      negative_match_count  <= negative_match_count_next;
      sign_candidates_alive <= sign_candidates_alive_next;
      is_negative           <= is_negative_next;
      magnitude             <= magnitude_next;
      digit_seen            <= digit_seen_next;
      failed                <= failed_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: output register plus a skid entry, so input keeps flowing
  // while one result waits. Input stalls only when both entries are full.
  // --------------------------------------------------------------------------
  dtp_pkg::out_item_t skid_item;
  logic               skid_valid;
  logic               res_push;
  logic               out_free;

  assign in_ready = !skid_valid;
  assign res_push = in_accept && last;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_push;
      end else begin
        out_valid  <= res_push;
      end
    end else if (res_push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_item <= skid_item;
        if (res_push) skid_item <= result;
      end else if (res_push) begin
        out_item <= result;
      end
    end else if (res_push) begin
      skid_item <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_token_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_item.last_unit) |=>
      (phase == dtp_pkg::PH_LEAD) && !digit_seen && !failed && (magnitude == '0))
    else $error("token state not cleared after the last unit");

  a_sign_body_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == dtp_pkg::PH_SIGN) |-> (magnitude == '0) && !digit_seen && !failed)
    else $error("body state touched before the sign resolved");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.ok) |-> (out_item.number_value == '0))
    else $error("rejected token carries a nonzero value");

  a_match_bound: assert property (@(posedge clk) disable iff (rst)
    (positive_match_count <= dtp_pkg::PREFIX_UNITS) &&
    (negative_match_count <= dtp_pkg::PREFIX_UNITS))
    else $error("prefix match count beyond prefix capacity");
`endif

endmodule

FILE: tb/int32_parse_checker.sv
// ----------------------------------------------------------------------------
// int32_parse_checker: result predictor and scoreboard for the token parser
// Follows the code unit, result and register traffic of the parser, works out
// the result of every token on its own and compares it with what comes back.
// ----------------------------------------------------------------------------
module int32_parse_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  dtp_pkg::in_item_t               in_item,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  dtp_pkg::out_item_t              out_item,
  input  logic                            cfg_write,
  input  logic [dtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dtp_pkg::TEXT_W-1:0]      cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              checked,
  output int                              parsed
);

  // bit positions in the set of sign candidates still alive
  localparam int CAND_POS    = 0;
  localparam int CAND_NEG    = 1;
  localparam int CAND_HYPHEN = 2;
  localparam int MAX_REPORTS = 10;

  logic [dtp_pkg::TEXT_W-1:0]  pos_text, neg_text;
  logic [dtp_pkg::LEN_W-1:0]   pos_len, neg_len;

  logic [dtp_pkg::PHASE_W-1:0] phase;
  int                          pos_cnt, neg_cnt;
  logic [dtp_pkg::ALIVE_W-1:0] alive;
  logic                        minus_flag, seen, bad;
  logic [dtp_pkg::MAG_W-1:0]   mag;

  dtp_pkg::out_item_t          due_results[$];

  function automatic logic blank(input logic [dtp_pkg::UNIT_W-1:0] c);
    return (c == dtp_pkg::CU_SPACE) || (c >= 16'd9 && c <= 16'd13);
  endfunction

  function automatic int clamp_len(input logic [dtp_pkg::LEN_W-1:0] l);
    return (l > 3'd4) ? 4 : int'(l);
  endfunction

  function automatic logic [dtp_pkg::UNIT_W-1:0] text_unit(
      input logic [dtp_pkg::TEXT_W-1:0] t, input int i);
    logic [dtp_pkg::TEXT_W-1:0] s;
    s = t >> (16 * (i & 3));
    return s[dtp_pkg::UNIT_W-1:0];
  endfunction

  task automatic clear_token();
    phase      = dtp_pkg::PH_LEAD;
    pos_cnt    = 0;
    neg_cnt    = 0;
    alive      = '1;
    minus_flag = 1'b0;
    mag        = '0;
    seen       = 1'b0;
    bad        = 1'b0;
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("error: %s", msg);
  endtask

  // Body of the token once the sign is settled: digits, blanks, NUL padding.
  task automatic feed_body(input logic [dtp_pkg::UNIT_W-1:0] c);
    logic [dtp_pkg::MAG_W+3:0] grown, cap;
    if (bad) return;
    case (phase)
      dtp_pkg::PH_DIGITS: begin
        if (c >= 16'h0030 && c <= 16'h0039) begin
          cap   = minus_flag ? {4'd0, dtp_pkg::NEG_LIMIT} : {4'd0, dtp_pkg::POS_LIMIT};
          grown = {4'd0, mag} * 36'd10 + {20'd0, c - 16'h0030};
          seen  = 1'b1;
          if (grown > cap) bad = 1'b1;
          else mag = grown[dtp_pkg::MAG_W-1:0];
        end else if (!seen) begin
          bad = 1'b1;
        end else if (blank(c)) begin
          phase = dtp_pkg::PH_TWS;
        end else if (c == dtp_pkg::CU_NUL) begin
          phase = dtp_pkg::PH_NUL;
        end else begin
          bad = 1'b1;
        end
      end
      dtp_pkg::PH_TWS: begin
        if (c == dtp_pkg::CU_NUL) phase = dtp_pkg::PH_NUL;
        else if (!blank(c)) bad = 1'b1;
      end
      default: begin
        if (c != dtp_pkg::CU_NUL) bad = 1'b1;
      end
    endcase
  endtask

  // One unit while the sign prefix is undecided. A longer winning prefix holds
  // the decision; on fallback the units already taken go through the body again.
  task automatic sign_step(input logic [dtp_pkg::UNIT_W-1:0] c, input logic fin);
    int                          plen, nlen, pc, nc, k, len, i;
    logic [dtp_pkg::ALIVE_W-1:0] al;
    logic [dtp_pkg::TEXT_W-1:0]  src_text;
    logic                        replay, neg, settled;
    plen     = clamp_len(pos_len);
    nlen     = clamp_len(neg_len);
    al       = alive;
    pc       = pos_cnt;
    nc       = neg_cnt;
    k        = al[CAND_POS] ? pc : (al[CAND_NEG] ? nc : 0);
    replay   = al[CAND_POS] || (al[CAND_NEG] && nc < nlen);
    src_text = al[CAND_POS] ? pos_text : neg_text;

    if (al[CAND_POS]) begin
      if (pc < plen && c == text_unit(pos_text, pc)) pc++;
      else al[CAND_POS] = 1'b0;
    end
    if (al[CAND_NEG] && nc < nlen) begin
      if (c == text_unit(neg_text, nc)) nc++;
      else al[CAND_NEG] = 1'b0;
    end
    if (al[CAND_HYPHEN] && k == 0 && c != dtp_pkg::CU_HYPHEN) al[CAND_HYPHEN] = 1'b0;
    k++;
    if (fin) begin
      if (al[CAND_POS] && pc < plen) al[CAND_POS] = 1'b0;
      if (al[CAND_NEG] && nc < nlen) al[CAND_NEG] = 1'b0;
    end
    pos_cnt = pc;
    neg_cnt = nc;
    alive   = al;

    settled = 1'b1;
    len     = 0;
    neg     = 1'b0;
    if (al[CAND_POS]) begin
      settled = (pc >= plen);
      len     = plen;
    end else if (al[CAND_NEG]) begin
      settled = (nc >= nlen);
      len     = nlen;
      neg     = 1'b1;
    end else if (al[CAND_HYPHEN]) begin
      len = 1;
      neg = 1'b1;
    end
    if (settled) begin
      phase      = dtp_pkg::PH_DIGITS;
      minus_flag = neg;
      if (replay) begin
        for (i = len; i + 1 < k; i++) feed_body(text_unit(src_text, i));
      end
      if (len < k) feed_body(c);
    end
  endtask

  task automatic parse_unit(input dtp_pkg::in_item_t it);
    logic [dtp_pkg::UNIT_W-1:0]  c;
    logic [dtp_pkg::ALIVE_W-1:0] al;
    dtp_pkg::out_item_t          res;
    int                          i;
    c = it.code_unit;
    if (phase == dtp_pkg::PH_LEAD) begin
      if (!blank(c)) begin
        al = '0;
        if (clamp_len(pos_len) > 0) al[CAND_POS] = 1'b1;
        if (clamp_len(neg_len) > 0) al[CAND_NEG] = 1'b1;
        if (clamp_len(neg_len) == 1) begin
          for (i = 0; i < dtp_pkg::MINUS_COUNT; i++) begin
            if (text_unit(neg_text, 0) == dtp_pkg::MINUS_LIKE[i]) al[CAND_HYPHEN] = 1'b1;
          end
        end
        phase   = dtp_pkg::PH_SIGN;
        pos_cnt = 0;
        neg_cnt = 0;
        alive   = al;
        sign_step(c, it.last_unit);
      end
    end else if (phase == dtp_pkg::PH_SIGN) begin
      sign_step(c, it.last_unit);
    end else begin
      feed_body(c);
    end

    if (it.last_unit) begin
      res.ok           = !bad && seen && (phase >= dtp_pkg::PH_DIGITS);
      res.number_value = '0;
      if (res.ok) res.number_value = minus_flag ? (~mag + 1'b1) : mag;
      due_results = {due_results, res};
      clear_token();
    end
  endtask

  always @(posedge clk) begin : watch
    dtp_pkg::out_item_t want;
    if (rst) begin
      pos_text = dtp_pkg::POSITIVE_TEXT_RST;
      pos_len  = dtp_pkg::POSITIVE_LENGTH_RST;
      neg_text = dtp_pkg::NEGATIVE_TEXT_RST;
      neg_len  = dtp_pkg::NEGATIVE_LENGTH_RST;
      clear_token();
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (due_results.size() == 0) begin
          flag_error($sformatf("result %0d (ok=%0b value=%0d) arrived with none due",
                               checked, out_item.ok, out_item.number_value));
        end else begin
          want = due_results.pop_front();
          if (out_item.ok !== want.ok || out_item.number_value !== want.number_value) begin
            flag_error($sformatf("result %0d: expected ok=%0b value=%0d, got ok=%0b value=%0d",
                                 checked, want.ok, want.number_value,
                                 out_item.ok, out_item.number_value));
          end
          if (want.ok) parsed++;
        end
      end
      // a unit taken at this edge still sees the registers from before the write
      if (in_valid && in_ready) parse_unit(in_item);
      if (cfg_write) begin
        case (cfg_index)
          dtp_pkg::CFG_POSITIVE_TEXT:   pos_text = cfg_data;
          dtp_pkg::CFG_POSITIVE_LENGTH: pos_len  = cfg_data[dtp_pkg::LEN_W-1:0];
          dtp_pkg::CFG_NEGATIVE_TEXT:   neg_text = cfg_data;
          dtp_pkg::CFG_NEGATIVE_LENGTH: neg_len  = cfg_data[dtp_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= due_results.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for decimal_int32_token_parser_unit
// Feeds directed and random UTF-16 tokens under a series of sign prefix
// settings, with random stalls on both channels; a checker beside the block
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;

  localparam int                         PHASES          = 12;
  localparam int                         UNITS_PER_PHASE = 125;
  localparam logic [dtp_pkg::UNIT_W-1:0] UNIT_PLUS       = 16'h002B;
  localparam logic [dtp_pkg::UNIT_W-1:0] UNIT_ZERO       = 16'h0030;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  dtp_pkg::in_item_t               in_item   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  dtp_pkg::out_item_t              out_item;
  logic                            cfg_write = 1'b0;
  logic [dtp_pkg::CFG_INDEX_W-1:0] cfg_index = dtp_pkg::CFG_POSITIVE_TEXT;
  logic [dtp_pkg::TEXT_W-1:0]      cfg_data  = '0;

  int errors, pending, checked, parsed;

  // Mirror of the registers, so tokens can be built around the live prefixes.
  logic [dtp_pkg::TEXT_W-1:0] cur_pt = dtp_pkg::POSITIVE_TEXT_RST;
  logic [dtp_pkg::LEN_W-1:0]  cur_pl = dtp_pkg::POSITIVE_LENGTH_RST;
  logic [dtp_pkg::TEXT_W-1:0] cur_nt = dtp_pkg::NEGATIVE_TEXT_RST;
  logic [dtp_pkg::LEN_W-1:0]  cur_nl = dtp_pkg::NEGATIVE_LENGTH_RST;

  logic                       steady   = 1'b0;  // no idling on either side while set
  logic                       tx_live  = 1'b0;  // in_valid as last driven
  int                         stall_left;
  int                         rx_gap;
  int                         units_sent;
  int                         reg_settings;
  logic [dtp_pkg::UNIT_W-1:0] tok[$];

  always #2 clk = ~clk;

  decimal_int32_token_parser_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  int32_parse_checker i_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .parsed    (parsed)
  );

  // Idle length before an item: mostly none or short, now and then the full
  // range, and nothing at all while the steady stretch runs.
  function automatic int pause_len();
    if (steady) return 0;
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 17);
      1:       return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  // Result side: after each accepted result, drop ready for a drawn number of
  // cycles, then raise it and hold it until the next result is taken.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end else if (out_valid && out_ready) begin
      rx_gap = pause_len();
      if (rx_gap > 0) begin
        out_ready  <= 1'b0;
        stall_left <= rx_gap;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one code unit and hold it until the block takes it. Lower valid
  // only when a gap is drawn, so valid is never dropped and raised in one step.
  task automatic push_unit(input logic [dtp_pkg::UNIT_W-1:0] c, input logic fin);
    int gap;
    gap = pause_len();
    if (gap > 0 && tx_live) begin
      in_valid <= 1'b0;
      tx_live  = 1'b0;
    end
    repeat (gap) @(posedge clk);
    in_item  <= '{code_unit: c, last_unit: fin};
    in_valid <= 1'b1;
    tx_live  = 1'b1;
    do @(posedge clk); while (!in_ready);
    units_sent++;
  endtask

  task automatic send_token();
    for (int i = 0; i < tok.size(); i++) push_unit(tok[i], i == tok.size() - 1);
  endtask

  task automatic halt_input();
    if (tx_live) begin
      in_valid <= 1'b0;
      tx_live  = 1'b0;
    end
  endtask

  // Hold the sender until every due result is back, then let the last unit
  // settle; registers may only change while the block is idle.
  task automatic drain();
    halt_input();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all four registers on consecutive cycles.
  task automatic set_regs(input logic [dtp_pkg::TEXT_W-1:0] pt,
                          input logic [dtp_pkg::LEN_W-1:0]  pl,
                          input logic [dtp_pkg::TEXT_W-1:0] nt,
                          input logic [dtp_pkg::LEN_W-1:0]  nl);
    cfg_write <= 1'b1;
    cfg_index <= dtp_pkg::CFG_POSITIVE_TEXT;
    cfg_data  <= pt;
    @(posedge clk);
    cfg_index <= dtp_pkg::CFG_POSITIVE_LENGTH;
    cfg_data  <= {{(dtp_pkg::TEXT_W-dtp_pkg::LEN_W){1'b0}}, pl};
    @(posedge clk);
    cfg_index <= dtp_pkg::CFG_NEGATIVE_TEXT;
    cfg_data  <= nt;
    @(posedge clk);
    cfg_index <= dtp_pkg::CFG_NEGATIVE_LENGTH;
    cfg_data  <= {{(dtp_pkg::TEXT_W-dtp_pkg::LEN_W){1'b0}}, nl};
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_pt = pt;
    cur_pl = pl;
    cur_nt = nt;
    cur_nl = nl;
    reg_settings++;
  endtask

  // Append one code unit to the token being built.
  task automatic tok_add(input logic [dtp_pkg::UNIT_W-1:0] u);
    tok = {tok, u};
  endtask

  task automatic tok_from(input string s);
    tok.delete();
    for (int i = 0; i < s.len(); i++) tok_add({8'd0, s[i]});
  endtask

  function automatic logic [dtp_pkg::UNIT_W-1:0] blank_unit();
    return $urandom_range(0, 1) ? dtp_pkg::CU_SPACE
                                : dtp_pkg::UNIT_W'($urandom_range(9, 13));
  endfunction

  // Anything a token might hold by accident, full 16-bit noise included.
  function automatic logic [dtp_pkg::UNIT_W-1:0] odd_unit();
    case ($urandom_range(0, 5))
      0:       return dtp_pkg::MINUS_LIKE[$urandom_range(0, dtp_pkg::MINUS_COUNT - 1)];
      1:       return dtp_pkg::UNIT_W'($urandom_range(16'h0030, 16'h0039));
      2:       return dtp_pkg::CU_NUL;
      3:       return blank_unit();
      default: return dtp_pkg::UNIT_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [dtp_pkg::UNIT_W-1:0] sign_unit();
    case ($urandom_range(0, 4))
      0:       return UNIT_PLUS;
      1:       return dtp_pkg::CU_HYPHEN;
      2:       return dtp_pkg::MINUS_LIKE[$urandom_range(0, dtp_pkg::MINUS_COUNT - 1)];
      3:       return dtp_pkg::UNIT_W'($urandom_range(16'h0041, 16'h005A));
      default: return odd_unit();
    endcase
  endfunction

  function automatic int clamp(input logic [dtp_pkg::LEN_W-1:0] l);
    return (l > 3'd4) ? 4 : int'(l);
  endfunction

  task automatic add_text(input logic [dtp_pkg::TEXT_W-1:0] t, input int n);
    for (int i = 0; i < n; i++) tok_add(t[dtp_pkg::UNIT_W*i +: dtp_pkg::UNIT_W]);
  endtask

  // Digits: lean on the int32 limits from both sides, plus long runs.
  task automatic add_digits();
    longint unsigned v;
    string           s;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1, 2:    v = 64'd2147483646 + 64'($urandom_range(0, 3));
      3:       v = 64'd4294967290 + 64'($urandom_range(0, 9));
      4:       v = {$urandom, $urandom} % 64'd100000000000000;
      5:       v = $urandom_range(0, 9999);
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) tok_add(UNIT_ZERO);
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) tok_add({8'd0, s[i]});
  endtask

  // Mostly well-formed tokens around the live prefixes; some broken, some noise.
  task automatic make_token();
    tok.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) tok_add(odd_unit());
      return;
    end
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) tok_add(blank_unit());
    case ($urandom_range(0, 5))
      0:       add_text(cur_pt, clamp(cur_pl));
      1:       add_text(cur_nt, clamp(cur_nl));
      2:       tok_add(dtp_pkg::CU_HYPHEN);
      3:       add_text($urandom_range(0, 1) ? cur_pt : cur_nt, $urandom_range(1, 3));
      default: ;
    endcase
    if ($urandom_range(0, 15) != 0) add_digits();
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) tok_add(blank_unit());
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) tok_add(dtp_pkg::CU_NUL);
    if ($urandom_range(0, 7) == 0 && tok.size() > 0)
      tok[$urandom_range(0, tok.size() - 1)] = odd_unit();
    if (tok.size() == 0) tok_add(odd_unit());
  endtask

  // Random prefixes; share the first unit now and then so both stay alive.
  task automatic random_regs();
    logic [dtp_pkg::TEXT_W-1:0] pt, nt;
    for (int i = 0; i < 4; i++) begin
      pt[dtp_pkg::UNIT_W*i +: dtp_pkg::UNIT_W] = sign_unit();
      nt[dtp_pkg::UNIT_W*i +: dtp_pkg::UNIT_W] = sign_unit();
    end
    if ($urandom_range(0, 2) == 0) nt[dtp_pkg::UNIT_W-1:0] = pt[dtp_pkg::UNIT_W-1:0];
    set_regs(pt, dtp_pkg::LEN_W'($urandom_range(0, 7)),
             nt, dtp_pkg::LEN_W'($urandom_range(0, 7)));
  endtask

  initial begin
    int mark, guard;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed tokens at reset prefixes: top code unit, blanks with sign and
    // NUL tail, most negative value, all blank, lone sign, NUL then a digit.
    tok = '{16'hFFFF};
    send_token();
    tok_from("\t\013+7 ");
    tok_add(dtp_pkg::CU_NUL);
    send_token();
    tok_from("-2147483648");
    send_token();
    tok_from(" ");
    send_token();
    tok_from("-");
    send_token();
    tok_from("0");
    tok_add(dtp_pkg::CU_NUL);
    tok_add(16'h0035);
    send_token();

    // Two-unit plus and a Unicode minus: token ending inside the prefix,
    // hyphen standing in for the minus, and the minus itself.
    drain();
    set_regs({32'd0, UNIT_PLUS, UNIT_PLUS}, 3'd2, {48'd0, dtp_pkg::MINUS_LIKE[3]}, 3'd1);
    tok_from("+");
    send_token();
    tok_from("-5");
    send_token();
    tok = '{dtp_pkg::MINUS_LIKE[3], 16'h0039};
    send_token();

    // Random part: one register setting per phase, fixed corners first.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_regs(dtp_pkg::POSITIVE_TEXT_RST, dtp_pkg::POSITIVE_LENGTH_RST,
                    dtp_pkg::NEGATIVE_TEXT_RST, dtp_pkg::NEGATIVE_LENGTH_RST);
        1: set_regs('0, 3'd0, '1, 3'd7);
        2: set_regs('1, 3'd7, '0, 3'd0);
        3: set_regs({48'd0, UNIT_PLUS}, 3'd1,
                    {48'd0, dtp_pkg::MINUS_LIKE[$urandom_range(0, dtp_pkg::MINUS_COUNT - 1)]},
                    3'd1);
        4: set_regs({32'd0, dtp_pkg::CU_HYPHEN, dtp_pkg::CU_HYPHEN}, 3'd2,
                    {48'd0, dtp_pkg::CU_HYPHEN}, 3'd1);
        5: set_regs({48'd0, UNIT_PLUS}, 3'd1,
                    {16'd0, 16'h0032, 16'h0031, dtp_pkg::CU_HYPHEN}, 3'd3);
        default: random_regs();
      endcase
      steady = (p == 6);
      mark   = units_sent;
      while (units_sent - mark < UNITS_PER_PHASE) begin
        make_token();
        send_token();
      end
    end
    steady = 1'b0;

    // Wind down: let every due result come back, with a bound.
    halt_input();
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (pending != 0) $display("%0d results never came back", pending);
    $display("covered %0d code units in %0d tokens over %0d register settings",
             units_sent, checked, reg_settings);
    $display("%0d tokens parsed to a number, %0d mismatches", parsed, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timed out with %0d results outstanding", pending);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dtp_pkg.sv
hw/rtl/decimal_int32_token_parser_unit.sv
tb/int32_parse_checker.sv
tb/testbench.sv
